// ===== rtl/tsg_pkg.sv =====
`default_nettype none

package tsg_pkg;

    // Field widths
    localparam int TYPE_W         = 16;
    localparam int CODE_W         = 16;
    localparam int VALUE_W        = 32;
    localparam int GAIN_W         = 16;
    localparam int GESTURE_W      = 3;
    localparam int CFG_IDX_W      = 1;

    // Coordinate format
    localparam int COORD_BITS     = 16;
    localparam int GAIN_FRAC_BITS = 10;

    // Scaler arithmetic widths
    localparam int PROD_W = VALUE_W + GAIN_W + 1;
    localparam int Q_W    = PROD_W - GAIN_FRAC_BITS;

    // Event numbering
    localparam logic [TYPE_W-1:0] EVT_KEY    = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] EVT_ABS    = TYPE_W'(3);
    localparam logic [CODE_W-1:0] CODE_TOUCH = CODE_W'(16'h014A);
    localparam logic [CODE_W-1:0] CODE_X     = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_Y     = CODE_W'(1);

    // Gesture classes
    localparam logic [GESTURE_W-1:0] G_TAP   = GESTURE_W'(0);
    localparam logic [GESTURE_W-1:0] G_UP    = GESTURE_W'(1);
    localparam logic [GESTURE_W-1:0] G_DOWN  = GESTURE_W'(2);
    localparam logic [GESTURE_W-1:0] G_LEFT  = GESTURE_W'(3);
    localparam logic [GESTURE_W-1:0] G_RIGHT = GESTURE_W'(4);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1024);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [TYPE_W-1:0]         event_type;
        logic [CODE_W-1:0]         event_code;
        logic signed [VALUE_W-1:0] event_value;
    } t_event;

    typedef struct packed {
        logic                 valid;
        logic [GESTURE_W-1:0] gesture;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/tsg_if.sv =====
`default_nettype none

interface tsg_event_if;
    import tsg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;

    modport source (output valid, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input event_type, input event_code,
                    input event_value, output ready);
endinterface

interface tsg_gesture_if;
    import tsg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [GESTURE_W-1:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

interface tsg_cfg_if;
    import tsg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsg_scale.sv =====
`default_nettype none

module tsg_scale (
    input  wire logic signed [tsg_pkg::VALUE_W-1:0] i_raw,
    input  wire logic [tsg_pkg::GAIN_W-1:0]         i_gain,
    output tsg_pkg::t_coord                         o_coord
);
    import tsg_pkg::*;

    localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(COORD_HI);
    localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-COORD_HI - 1);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        (PROD_W'(1) << GAIN_FRAC_BITS) - PROD_W'(1);

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [Q_W-1:0]    q;

    // Q6.10 multiply, divide toward zero, clamp
    always_comb begin
        prod   = PROD_W'(i_raw) * PROD_W'($signed({1'b0, i_gain}));
        biased = prod + (prod[PROD_W-1] ? ROUND_BIAS : PROD_W'(0));
        q      = Q_W'(biased >>> GAIN_FRAC_BITS);
        if (q > Q_HI) begin
            o_coord = COORD_BITS'(Q_HI);
        end else if (q < Q_LO) begin
            o_coord = COORD_BITS'(Q_LO);
        end else begin
            o_coord = COORD_BITS'(q);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tsg_track.sv =====
`default_nettype none

module tsg_track (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire tsg_pkg::t_event             i_evt,
    input  wire logic [tsg_pkg::GAIN_W-1:0]  i_x_gain,
    input  wire logic [tsg_pkg::GAIN_W-1:0]  i_y_gain,
    output tsg_pkg::t_result                 o_res
);
    import tsg_pkg::*;

    logic   r_touching;
    t_coord r_cur_x;
    t_coord r_cur_y;
    t_coord r_start_x;
    t_coord r_start_y;

    logic   n_touching;
    t_coord n_cur_x;
    t_coord n_cur_y;
    t_coord n_start_x;
    t_coord n_start_y;

    logic                  is_abs;
    logic                  is_touch;
    logic                  is_press;
    logic                  is_release;
    logic [GAIN_W-1:0]     gain_sel;
    t_coord                scaled;
    logic signed [COORD_BITS:0] dx_s;
    logic signed [COORD_BITS:0] dy_s;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [GESTURE_W-1:0]  cls;

    // One scaler, shared by both axes
    assign gain_sel = (i_evt.event_code == CODE_Y) ? i_y_gain : i_x_gain;

    tsg_scale u_scale (
        .i_raw   (i_evt.event_value),
        .i_gain  (gain_sel),
        .o_coord (scaled)
    );

    assign is_abs     = (i_evt.event_type == EVT_ABS);
    assign is_touch   = (i_evt.event_type == EVT_KEY) && (i_evt.event_code == CODE_TOUCH);
    assign is_press   = is_touch && (i_evt.event_value > 0);
    assign is_release = is_touch && (i_evt.event_value == 0) && r_touching;

    // Drift classification
    always_comb begin
        dx_s = (COORD_BITS+1)'(r_cur_x) - (COORD_BITS+1)'(r_start_x);
        dy_s = (COORD_BITS+1)'(r_cur_y) - (COORD_BITS+1)'(r_start_y);
        dx   = dx_s[COORD_BITS] ? (COORD_BITS+1)'(-dx_s) : (COORD_BITS+1)'(dx_s);
        dy   = dy_s[COORD_BITS] ? (COORD_BITS+1)'(-dy_s) : (COORD_BITS+1)'(dy_s);
        priority if ((r_cur_x == r_start_x) && (r_cur_y == r_start_y)) begin
            cls = G_TAP;
        end else if (dx > dy) begin
            cls = (r_cur_x > r_start_x) ? G_RIGHT : G_LEFT;
        end else begin
            cls = (r_cur_y > r_start_y) ? G_DOWN : G_UP;
        end
    end

    assign o_res.valid   = is_release;
    assign o_res.gesture = cls;

    always_comb begin
        n_touching = r_touching;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        if (i_adv) begin
            if (is_abs && (i_evt.event_code == CODE_X)) begin
                n_cur_x = scaled;
            end
            if (is_abs && (i_evt.event_code == CODE_Y)) begin
                n_cur_y = scaled;
            end
            if (is_press && !r_touching) begin
                n_touching = 1'b1;
                n_start_x  = r_cur_x;
                n_start_y  = r_cur_y;
            end
            if (is_release) begin
                n_touching = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching <= 1'b0;
            r_cur_x    <= '1;
            r_cur_y    <= '1;
        end else begin
            r_touching <= n_touching;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
        end
    end

    // Start point: written by a press before any release reads it
    always_ff @(posedge i_clk) begin
        r_start_x <= n_start_x;
        r_start_y <= n_start_y;
    end

    a_release_ends_touch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.valid) |=> !r_touching)
        else $error("touch still held after a release transfer");

    a_press_latches_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && is_press && !r_touching) |=>
            (r_touching && (r_start_x == $past(r_cur_x)) && (r_start_y == $past(r_cur_y))))
        else $error("press did not latch the start point");

    a_no_gesture_when_released : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_touching |-> !o_res.valid)
        else $error("gesture produced without an active touch");

endmodule

`default_nettype wire

// ===== rtl/tsg_outq.sv =====
`default_nettype none

module tsg_outq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [tsg_pkg::GESTURE_W-1:0]  i_gesture,
    output logic                                o_full,
    tsg_gesture_if.source                       o_gst
);
    import tsg_pkg::*;

    logic [1:0]           r_cnt;
    logic [GESTURE_W-1:0] r_d0;
    logic [GESTURE_W-1:0] r_d1;
    logic [1:0]           n_cnt;
    logic [GESTURE_W-1:0] n_d0;
    logic [GESTURE_W-1:0] n_d1;
    logic                 pop;

    assign pop           = (r_cnt != 2'd0) && o_gst.ready;
    assign o_full        = (r_cnt == 2'd2);
    assign o_gst.valid   = (r_cnt != 2'd0);
    assign o_gst.gesture = r_d0;

    // Two-entry queue: head in r_d0
    always_comb begin
        n_cnt = r_cnt;
        n_d0  = r_d0;
        n_d1  = r_d1;
        unique case ({i_push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_d0 = i_gesture;
                end else begin
                    n_d1 = i_gesture;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_d0  = r_d1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_d0 = i_gesture;
                end else begin
                    n_d0 = r_d1;
                    n_d1 = i_gesture;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("push into full output queue");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_head_kept_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_gst.valid && !o_gst.ready) |=> (o_gst.valid && $stable(o_gst.gesture)))
        else $error("queued gesture changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/touch_swipe_gesture_classifier.sv =====
`default_nettype none

// Touch swipe gesture classifier.
// i_evt  : touch events (event_type, event_code, event_value), Linux numbering.
//          Absolute X/Y events update the current position (scaled by the gain,
//          truncated toward zero, clamped to signed 16 bits); touch key events
//          press/release the contact.
// o_gst  : one 3-bit gesture per release that follows a press
//          (tap, up, down, left, right); other events give no transfer.
// i_cfg  : gain writes, index 0 = X gain, index 1 = Y gain (Q6.10). Always
//          ready; write only while no event is in flight.
// Timing : an event is taken into the input register, processed from there, and
//          its gesture is registered into the output queue, then shown on o_gst.
//          One event per cycle while the output queue is not full; the scaler
//          multiply (32x16) and the drift compare are combinational between the
//          input register and the output queue.
// Stall  : a two-entry output queue absorbs a stalled receiver; i_evt.ready
//          drops only when the queue is full and the input register is held.
// Reset  : synchronous, active low. Gains return to 1.0, contact released,
//          current position -1/-1, queues empty. No clearing pass.
module touch_swipe_gesture_classifier (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tsg_event_if.sink     i_evt,
    tsg_cfg_if.sink       i_cfg,
    tsg_gesture_if.source o_gst
);
    import tsg_pkg::*;

    logic [GAIN_W-1:0] r_x_gain;
    logic [GAIN_W-1:0] r_y_gain;
    logic              r_in_valid;
    t_event            r_in;

    logic              q_full;
    logic              adv;
    t_result           res;

    // Processing advances whenever the queue has room for a result
    assign adv         = r_in_valid && !q_full;
    assign i_evt.ready = !r_in_valid || !q_full;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain <= GAIN_RESET;
            r_y_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_X_GAIN: r_x_gain <= i_cfg.data;
                REG_Y_GAIN: r_y_gain <= i_cfg.data;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in.event_type  <= i_evt.event_type;
            r_in.event_code  <= i_evt.event_code;
            r_in.event_value <= i_evt.event_value;
        end
    end

    // Touch state and classification
    tsg_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_evt    (r_in),
        .i_x_gain (r_x_gain),
        .i_y_gain (r_y_gain),
        .o_res    (res)
    );

    // Result queue toward the receiver
    tsg_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (adv && res.valid),
        .i_gesture (res.gesture),
        .o_full    (q_full),
        .o_gst     (o_gst)
    );

    a_input_held_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && q_full) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost an event while stalled");

    a_ready_tracks_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_evt.ready |-> (r_in_valid && q_full))
        else $error("input stalled without a full queue");

    a_gain_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_x_gain == GAIN_RESET) && (r_y_gain == GAIN_RESET)))
        else $error("gains not restored by reset");

endmodule

`default_nettype wire

// ===== sim/gesture_checker.sv =====
`timescale 1ns / 100ps

// Watches the event, gain and gesture channels, tracks touch state and
// compares every gesture transfer against the oldest predicted one.
module gesture_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsg_event_if      i_evt,
    tsg_cfg_if        i_cfg,
    tsg_gesture_if    i_gst,
    output int        o_mismatches,
    output int        o_outstanding
);
    import tsg_pkg::*;

    logic [GAIN_W-1:0]    gain_x;
    logic [GAIN_W-1:0]    gain_y;
    logic                 touch_down;
    t_coord               pos_x;
    t_coord               pos_y;
    t_coord               anchor_x;
    t_coord               anchor_y;
    logic [GESTURE_W-1:0] gesture_q[$];
    logic [GESTURE_W-1:0] want;
    int                   fail_total;

    // Q6.10 scale, truncate toward zero, clamp to the signed coordinate range
    function automatic t_coord scale_axis(input logic signed [VALUE_W-1:0] raw,
                                          input logic [GAIN_W-1:0] gain);
        longint prod;
        longint q;
        longint hi;
        longint lo;
        hi   = (longint'(1) << (COORD_BITS - 1)) - 1;
        lo   = -hi - 1;
        prod = longint'(raw) * longint'({1'b0, gain});
        q    = prod / (longint'(1) << GAIN_FRAC_BITS);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return t_coord'(q);
    endfunction

    function automatic logic [GESTURE_W-1:0] swipe_class(input t_coord ex, input t_coord ey,
                                                         input t_coord sx, input t_coord sy);
        longint dx;
        longint dy;
        if (ex == sx && ey == sy) return G_TAP;
        dx = (ex > sx) ? longint'(ex) - longint'(sx) : longint'(sx) - longint'(ex);
        dy = (ey > sy) ? longint'(ey) - longint'(sy) : longint'(sy) - longint'(ey);
        // tie goes to the vertical axis
        if (dx > dy) return (ex > sx) ? G_RIGHT : G_LEFT;
        return (ey > sy) ? G_DOWN : G_UP;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: gesture mismatch: %s", $time, what);
        fail_total++;
    endtask

    task automatic track_touch_event(input logic [TYPE_W-1:0] ty,
                                     input logic [CODE_W-1:0] cd,
                                     input logic signed [VALUE_W-1:0] v);
        if (ty == EVT_ABS) begin
            if (cd == CODE_X) pos_x = scale_axis(v, gain_x);
            else if (cd == CODE_Y) pos_y = scale_axis(v, gain_y);
        end else if (ty == EVT_KEY && cd == CODE_TOUCH) begin
            if (v > 0) begin
                if (!touch_down) begin
                    touch_down = 1'b1;
                    anchor_x   = pos_x;
                    anchor_y   = pos_y;
                end
            end else if (v == 0 && touch_down) begin
                touch_down = 1'b0;
                gesture_q.push_back(swipe_class(pos_x, pos_y, anchor_x, anchor_y));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_x     = GAIN_RESET;
            gain_y     = GAIN_RESET;
            touch_down = 1'b0;
            pos_x      = '1;
            pos_y      = '1;
            anchor_x   = '0;
            anchor_y   = '0;
            fail_total = 0;
            gesture_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_X_GAIN: gain_x = i_cfg.data;
                    REG_Y_GAIN: gain_y = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_evt.valid && i_evt.ready)
                track_touch_event(i_evt.event_type, i_evt.event_code, i_evt.event_value);
            if (i_gst.valid && i_gst.ready) begin
                if (gesture_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected gesture %0d", i_gst.gesture));
                end else begin
                    want = gesture_q.pop_front();
                    if (i_gst.gesture !== want)
                        report_mismatch($sformatf("gesture %0d, expected %0d",
                                                  i_gst.gesture, want));
                end
            end
        end
        o_mismatches  <= fail_total;
        o_outstanding <= gesture_q.size();
    end

endmodule

// ===== sim/touch_swipe_gesture_classifier_test.sv =====
`timescale 1ns / 100ps

// Top of the gesture classifier bench: clock, reset, event and gain stimulus,
// receiver backpressure and the final verdict. All prediction and comparison
// lives in gesture_checker.
module touch_swipe_gesture_classifier_test;
    import tsg_pkg::*;

    // Generous bound: ~1500 events, each with worst-case sender gap and
    // receiver stall, still lands far below this.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 6;   // padding after the queue drains
    localparam int ITEMS_PER_GAIN = 160;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   outstanding;
    int   cycle_count;

    // Set while a whole swipe is sent back to back (no sender gaps)
    bit   burst;

    // Receiver-side stall pattern state
    logic sink_open;
    int   stretch_left;

    tsg_event_if   evt_bus ();
    tsg_cfg_if     cfg_bus ();
    tsg_gesture_if gst_bus ();

    touch_swipe_gesture_classifier DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_bus),
        .i_cfg   (cfg_bus),
        .o_gst   (gst_bus)
    );

    gesture_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (evt_bus),
        .i_cfg         (cfg_bus),
        .i_gst         (gst_bus),
        .o_mismatches  (mismatch_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a gesture never shows up or a handshake hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Gesture receiver: alternating open / stalled stretches. A few stalls are
    // long enough to fill the output queue and push back on the event side;
    // some open stretches are long with no stall at all.
    always @(negedge i_clk) begin
        if (stretch_left == 0) begin
            sink_open = !sink_open;
            if (sink_open)
                stretch_left = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 30)
                                                           : $urandom_range(8, 1);
            else
                stretch_left = ($urandom_range(14, 0) == 0) ? $urandom_range(45, 15)
                                                            : $urandom_range(3, 1);
        end else begin
            stretch_left--;
        end
        gst_bus.ready <= sink_open;
    end

    // Sender gap: mostly none, often short, rarely long
    function automatic int pick_event_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    // One event transfer, then an optional idle gap with valid low
    task automatic send_event(input logic [TYPE_W-1:0] ty,
                              input logic [CODE_W-1:0] cd,
                              input logic signed [VALUE_W-1:0] v);
        int gap;
        @(negedge i_clk);
        evt_bus.valid       <= 1'b1;
        evt_bus.event_type  <= ty;
        evt_bus.event_code  <= cd;
        evt_bus.event_value <= v;
        @(posedge i_clk);
        while (!evt_bus.ready) @(posedge i_clk);
        gap = burst ? 0 : pick_event_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            evt_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic touch(input logic signed [VALUE_W-1:0] v);
        send_event(EVT_KEY, CODE_TOUCH, v);
    endtask

    task automatic move_x(input logic signed [VALUE_W-1:0] v);
        send_event(EVT_ABS, CODE_X, v);
    endtask

    task automatic move_y(input logic signed [VALUE_W-1:0] v);
        send_event(EVT_ABS, CODE_Y, v);
    endtask

    // Drop valid and let every predicted gesture drain, plus SETTLE_CYCLES of padding
    // for events that produce no transfer but may still be in the pipeline.
    task automatic settle();
        @(negedge i_clk);
        evt_bus.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Raw coordinate: mostly small drifts (so ties and taps happen), some around
    // the 16-bit limit (+/-40000), some fully random 32-bit to hit saturation.
    function automatic logic signed [VALUE_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return int'($urandom_range(600, 0)) - 300;
        if (r < 90) return int'($urandom_range(80000, 0)) - 40000;
        return $urandom();
    endfunction

    // Positive touch value: usually 1, sometimes anything up to the max
    function automatic logic signed [VALUE_W-1:0] pick_press();
        logic signed [VALUE_W-1:0] v;
        if ($urandom_range(3, 0) != 0) return 1;
        v = $urandom() & 32'h7FFF_FFFF;
        if (v == 0) v = 1;
        return v;
    endfunction

    // Well-formed swipe with random content: optional start position, press,
    // a few moves (with the odd repeated press or negative touch value mixed
    // in), release. No moves at all gives a tap.
    task automatic play_swipe(output int sent);
        int moves;
        int k;
        sent  = 0;
        burst = ($urandom_range(4, 0) == 0);
        if ($urandom_range(1, 0) != 0) begin
            move_x(pick_coord());
            sent++;
        end
        if ($urandom_range(1, 0) != 0) begin
            move_y(pick_coord());
            sent++;
        end
        touch(pick_press());
        sent++;
        moves = $urandom_range(3, 0);
        for (k = 0; k < moves; k++) begin
            case ($urandom_range(9, 0))
                0:             touch(pick_press());
                1:             touch($urandom() | 32'h8000_0000);
                2, 3, 4, 5:    move_x(pick_coord());
                default:       move_y(pick_coord());
            endcase
            sent++;
        end
        touch(0);
        sent++;
        burst = 1'b0;
    endtask

    // Broken or foreign traffic: random type/code, unused axes, other keys,
    // stray releases and touches with the wrong type.
    task automatic send_noise();
        case ($urandom_range(4, 0))
            0:       send_event(16'($urandom()), 16'($urandom()), $urandom());
            1:       send_event(EVT_ABS, 16'($urandom_range(65535, 2)), $urandom());
            2:       send_event(EVT_KEY, 16'($urandom()), $urandom());
            3:       touch(0);
            default: send_event(16'($urandom()), CODE_TOUCH, 1);
        endcase
    endtask

    task automatic run_random(input int target);
        int done;
        int sent;
        done = 0;
        while (done < target) begin
            if ($urandom_range(99, 0) < 85) begin
                play_swipe(sent);
                done += sent;
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] gx;
        logic [GAIN_W-1:0] gy;
        int                phase;

        // Every block input known from time zero
        i_rst_n             = 1'b0;
        cycle_count         = 0;
        burst               = 1'b0;
        sink_open           = 1'b0;
        stretch_left        = 0;
        evt_bus.valid       = 1'b0;
        evt_bus.event_type  = '0;
        evt_bus.event_code  = '0;
        evt_bus.event_value = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        gst_bus.ready       = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset gains (1.0 on both axes)
        touch(0);                         // release while released: no gesture
        touch(1);                         // press at reset position -1/-1
        touch(0);                         // nothing moved: tap
        touch(1);
        touch(5);                         // press while pressed: start kept
        move_x(100);
        touch(-7);                        // negative touch value: ignored
        touch(0);                         // right
        touch(32'sh7FFF_FFFF);            // largest press value
        move_y(32'sh8000_0000);           // most negative raw value saturates
        touch(0);                         // up
        touch(1);
        move_y(500);
        touch(0);                         // down
        touch(1);
        move_x(-3000);
        touch(0);                         // left
        touch(1);
        move_x(-2990);
        move_y(510);
        touch(0);                         // equal drift on both axes: vertical
        send_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(EVT_ABS, 16'h0002, 12345);
        send_event(EVT_KEY, CODE_X, 0);

        // Random part, one phase per gain setting. Gains only change with the
        // pipeline empty; zero gain collapses an axis, max gain saturates it.
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       begin gx = GAIN_RESET;          gy = GAIN_RESET;          end
                1:       begin gx = '0;                  gy = '1;                  end
                2:       begin gx = '1;                  gy = '0;                  end
                3:       begin gx = 16'($urandom());     gy = 16'($urandom());     end
                4:       begin gx = 16'd512;             gy = 16'd2048;            end
                5:       begin gx = 16'($urandom());     gy = 16'($urandom());     end
                default: begin gx = GAIN_RESET;          gy = GAIN_RESET;          end
            endcase
            if (phase != 0) begin
                settle();
                write_gain(REG_X_GAIN, gx);
                write_gain(REG_Y_GAIN, gy);
            end
            run_random(ITEMS_PER_GAIN);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tsg_pkg.sv
rtl/tsg_if.sv
rtl/tsg_scale.sv
rtl/tsg_track.sv
rtl/tsg_outq.sv
rtl/touch_swipe_gesture_classifier.sv
sim/gesture_checker.sv
sim/touch_swipe_gesture_classifier_test.sv
